[rtl/core/qdo_pkg.sv]
// Shared types, opcodes and helpers for the quadrature decoder / odometry block.
// No dependencies; qdo_step and the top level refer to it by scoped names.
package qdo_pkg;

    // Operation codes carried in the input beat
    localparam logic [2:0] OP_EDGE  = 3'd0;
    localparam logic [2:0] OP_POLL  = 3'd1;
    localparam logic [2:0] OP_HWD   = 3'd2;
    localparam logic [2:0] OP_TAKE  = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;

    // Configuration register indexes
    localparam logic CFG_QUAD_MODE   = 1'b0;
    localparam logic CFG_REVERSE_DIR = 1'b1;

    // Quadrature step codes
    localparam logic signed [1:0] STEP_Z = 2'sb00;
    localparam logic signed [1:0] STEP_P = 2'sb01;
    localparam logic signed [1:0] STEP_N = 2'sb11;

    // Step indexed by {previous A/B, current A/B}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
        STEP_Z, STEP_P, STEP_N, STEP_Z,
        STEP_N, STEP_Z, STEP_Z, STEP_P,
        STEP_P, STEP_Z, STEP_Z, STEP_N,
        STEP_Z, STEP_N, STEP_P, STEP_Z
    };

    localparam logic [31:0]        U32_MAX = 32'hFFFF_FFFF;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               quad_mode;
        logic               reverse_dir;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic               pin_a;
        logic               pin_b;
        logic signed [15:0] hw_delta;
    } item_t;

    typedef struct packed {
        logic [1:0]         prev_ab;
        logic [1:0]         polled_ab;
        logic [31:0]        edge_cnt;
        logic signed [31:0] signed_cnt;
        logic [31:0]        invalid_cnt;
        logic [31:0]        polled_cnt;
        logic [31:0]        edge_base;
        logic signed [31:0] signed_base;
    } state_t;

    typedef struct packed {
        logic [31:0]        edge_total;
        logic signed [31:0] signed_total;
        logic [31:0]        invalid_total;
        logic [31:0]        polled_total;
        logic [31:0]        edge_incr;
        logic signed [31:0] signed_delta_out;
    } result_t;

    // Unsigned add that sticks at all ones
    function automatic logic [31:0] sat_add_u(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? U32_MAX : sum[31:0];
    endfunction

    // Signed add of a 17-bit increment that sticks at the 32-bit limits
    function automatic logic signed [31:0] sat_add_s(input logic signed [31:0] a,
                                                     input logic signed [16:0] d);
        logic [32:0] sum;
        sum = {a[31], a} + {{16{d[16]}}, d};
        if (sum[32] != sum[31]) begin
            return sum[32] ? S32_MIN : S32_MAX;
        end
        return sum[31:0];
    endfunction

endpackage

[rtl/core/qdo_step.sv]
// Next-state and result logic for one operation of the quadrature decoder.
// Purely combinational; uses qdo_pkg types, table and saturating helpers.
module qdo_step (
    input  qdo_pkg::cfg_t    cfg,
    input  qdo_pkg::item_t   item,
    input  qdo_pkg::state_t  st,
    output qdo_pkg::state_t  st_next,
    output qdo_pkg::result_t res
);

    logic [1:0]         cur_ab;
    logic signed [1:0]  step;
    logic signed [16:0] step_dir;
    logic signed [16:0] unit_dir;
    logic signed [16:0] hw_ext;
    logic signed [16:0] hw_dir;
    logic [16:0]        hw_mag;
    logic [31:0]        ed;
    logic [31:0]        sd;

    // Level code: B is forced low in single-phase mode
    assign cur_ab = cfg.quad_mode ? {item.pin_a, item.pin_b} : {item.pin_a, 1'b0};

    // Decode the transition and apply direction
    assign step     = qdo_pkg::STEP_TABLE[{st.prev_ab, cur_ab}];
    assign step_dir = cfg.reverse_dir ? -{{15{step[1]}}, step} : {{15{step[1]}}, step};
    assign unit_dir = cfg.reverse_dir ? -17'sd1 : 17'sd1;

    // Hardware delta: signed increment and its magnitude
    assign hw_ext = {item.hw_delta[15], item.hw_delta};
    assign hw_dir = cfg.reverse_dir ? -hw_ext : hw_ext;
    assign hw_mag = hw_ext[16] ? 17'(-hw_ext) : 17'(hw_ext);

    always_comb begin
        st_next = st;
        ed      = '0;
        sd      = '0;
        unique case (item.opcode)
            qdo_pkg::OP_EDGE: begin
                if (!cfg.quad_mode) begin
                    st_next.edge_cnt   = qdo_pkg::sat_add_u(st.edge_cnt, 32'd1);
                    st_next.signed_cnt = qdo_pkg::sat_add_s(st.signed_cnt, unit_dir);
                end else if (step != qdo_pkg::STEP_Z) begin
                    st_next.edge_cnt   = qdo_pkg::sat_add_u(st.edge_cnt, 32'd1);
                    st_next.signed_cnt = qdo_pkg::sat_add_s(st.signed_cnt, step_dir);
                end else if (cur_ab != st.prev_ab) begin
                    st_next.invalid_cnt = qdo_pkg::sat_add_u(st.invalid_cnt, 32'd1);
                end
                st_next.prev_ab = cur_ab;
            end
            qdo_pkg::OP_POLL: begin
                if (cur_ab != st.polled_ab) begin
                    st_next.polled_cnt = qdo_pkg::sat_add_u(st.polled_cnt, 32'd1);
                    st_next.polled_ab  = cur_ab;
                end
            end
            qdo_pkg::OP_HWD: begin
                if (item.hw_delta != 16'sd0) begin
                    st_next.edge_cnt   = qdo_pkg::sat_add_u(st.edge_cnt, {15'd0, hw_mag});
                    st_next.polled_cnt = qdo_pkg::sat_add_u(st.polled_cnt, {15'd0, hw_mag});
                    st_next.signed_cnt = qdo_pkg::sat_add_s(st.signed_cnt, hw_dir);
                end
            end
            qdo_pkg::OP_TAKE: begin
                ed                  = st.edge_cnt - st.edge_base;
                sd                  = st.signed_cnt - st.signed_base;
                st_next.edge_base   = st.edge_cnt;
                st_next.signed_base = st.signed_cnt;
            end
            qdo_pkg::OP_CLEAR: begin
                st_next.edge_cnt    = '0;
                st_next.signed_cnt  = '0;
                st_next.invalid_cnt = '0;
                st_next.polled_cnt  = '0;
                st_next.edge_base   = '0;
                st_next.signed_base = '0;
                st_next.prev_ab     = cur_ab;
                st_next.polled_ab   = cur_ab;
            end
            default: begin
                // Unused opcodes: report totals, change nothing
            end
        endcase
    end

    // Assemble the result beat from the updated counters
    always_comb begin
        res.edge_total       = st_next.edge_cnt;
        res.signed_total     = st_next.signed_cnt;
        res.invalid_total    = st_next.invalid_cnt;
        res.polled_total     = st_next.polled_cnt;
        res.edge_incr        = ed;
        res.signed_delta_out = sd;
    end

endmodule

[rtl/core/quadrature_decoder_odometry.sv]
// Top level of the quadrature decoder with saturating odometry counters.
// Depends on qdo_pkg and qdo_step.
//
//  Channel | Direction | Handshake             | Payload
//  s_      | in        | s_valid / s_ready     | opcode, pin_a, pin_b, hw_delta
//  m_      | out       | m_valid / m_ready     | six totals and deltas
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while m_ready is high; an accepted beat waits in the
// input register until the result register is free, then is loaded there for taking.
// The state update for a beat and its result load happen in the same cycle.
// Reset (aresetn low, synchronous) empties both stages and restores the
// counters and mode registers. A stalled m_ready holds the result and
// stops the input register; s_ready drops only when both stages are full.
module quadrature_decoder_odometry (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic               s_pin_a,
    input  logic               s_pin_b,
    input  logic signed [15:0] s_hw_delta,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_edge_total,
    output logic signed [31:0] m_signed_total,
    output logic [31:0]        m_invalid_total,
    output logic [31:0]        m_polled_total,
    output logic [31:0]        m_edge_incr,
    output logic signed [31:0] m_signed_delta_out,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic               cfg_data
);

    logic              in_valid_reg;
    qdo_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    qdo_pkg::result_t  out_res_reg;
    qdo_pkg::state_t   state_reg;
    qdo_pkg::state_t   state_next;
    qdo_pkg::result_t  res_next;
    qdo_pkg::cfg_t     cfg_reg;
    logic              advance;

    // Move a beat to the output when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Capture the input beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{opcode: s_opcode, pin_a: s_pin_a, pin_b: s_pin_b,
                             hw_delta: s_hw_delta};
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quad_mode   <= 1'b1;
            cfg_reg.reverse_dir <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                qdo_pkg::CFG_QUAD_MODE:   cfg_reg.quad_mode   <= cfg_data;
                qdo_pkg::CFG_REVERSE_DIR: cfg_reg.reverse_dir <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    qdo_step u_step (
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Commit the counter state as the beat moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_edge_total       = out_res_reg.edge_total;
    assign m_signed_total     = out_res_reg.signed_total;
    assign m_invalid_total    = out_res_reg.invalid_total;
    assign m_polled_total     = out_res_reg.polled_total;
    assign m_edge_incr        = out_res_reg.edge_incr;
    assign m_signed_delta_out = out_res_reg.signed_delta_out;

endmodule

[rtl/core/qdo_checker.sv]
// Port-level checks for quadrature_decoder_odometry, bound to the top level.
// Depends only on the top level's ports.
module qdo_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_ready,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_edge_total,
    input  logic [31:0] m_edge_incr
);

    // Drop the result flag after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_edge_total) && $stable(m_edge_incr))
        else $error("stalled result changed");

    // Edge increment never exceeds the edge count since the baseline only trails it
    a_delta_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_edge_incr <= m_edge_total)
        else $error("edge increment above edge total");

    // Input side never blocks while the output side is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind quadrature_decoder_odometry qdo_checker u_qdo_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_edge_total (m_edge_total),
    .m_edge_incr  (m_edge_incr)
);
